>>> rtl/light_volume_box_cull_assert.svh
// Assertion macros shared by the light volume box cull design.
`ifndef LIGHT_VOLUME_BOX_CULL_ASSERT_SVH
`define LIGHT_VOLUME_BOX_CULL_ASSERT_SVH
`ifndef SYNTHESIS
`define LVBC_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);
`define LVBC_ASSERT_NEXT(label, cause, effect, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cause) |=> (effect)) \
		else $error(msg);
`else
`define LVBC_ASSERT(label, prop, msg)
`define LVBC_ASSERT_NEXT(label, cause, effect, msg)
`endif
`endif

>>> rtl/lvbc_pkg.sv
// Types and constants of the light volume box cull block.
`timescale 1ns / 1ps
package lvbc_pkg;
	localparam int COORD_W = 32;
	localparam int RADIUS_W = 31;
	localparam int DIR_W = 48;
	localparam int COS_W = 14;
	localparam int CFG_DATA_W = 48;
	localparam int CFG_IDX_W = 3;
	localparam logic [30:0] SQRT3_Q30 = 31'd1859775393;
	localparam int DIV_W = 48;
	localparam int DIV_STEP = 4;
	localparam int DIV_STAGES = DIV_W / DIV_STEP;
	localparam int K_W = 40;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_MODE = 3'd0,
		CFG_POS_X = 3'd1,
		CFG_POS_Y = 3'd2,
		CFG_POS_Z = 3'd3,
		CFG_RADIUS = 3'd4,
		CFG_CONE_DIR = 3'd5,
		CFG_COS_OUTER = 3'd6
	} cfg_idx_t;

	typedef struct packed {
		logic inst;
		logic pt;
		logic apex;
	} flags_t;

	typedef struct packed {
		logic [DIV_W-1:0] num;
		logic [14:0] rem;
		logic [2:0][33:0] rel;
		flags_t flags;
	} div_t;
endpackage

>>> rtl/lvbc_box_if.sv
// Box input channel of the light volume box cull block.
`timescale 1ns / 1ps
interface lvbc_box_if import lvbc_pkg::*; ();
	logic valid;
	logic ready;
	logic [COORD_W-1:0] box_min_x;
	logic [COORD_W-1:0] box_min_y;
	logic [COORD_W-1:0] box_min_z;
	logic [COORD_W-1:0] box_max_x;
	logic [COORD_W-1:0] box_max_y;
	logic [COORD_W-1:0] box_max_z;
	logic instanced;

	modport source (output valid, box_min_x, box_min_y, box_min_z, box_max_x, box_max_y,
		box_max_z, instanced, input ready);
	modport sink (input valid, box_min_x, box_min_y, box_min_z, box_max_x, box_max_y,
		box_max_z, instanced, output ready);
endinterface

>>> rtl/lvbc_res_if.sv
// Result channel of the light volume box cull block.
`timescale 1ns / 1ps
interface lvbc_res_if;
	logic valid;
	logic ready;
	logic cast_shadow;

	modport source (output valid, cast_shadow, input ready);
	modport sink (input valid, cast_shadow, output ready);
endinterface

>>> rtl/light_volume_box_cull.sv
// Top level of the light volume box cull block: sphere and cone tests of one box a cycle unless stalled.
`timescale 1ns / 1ps
// Channel   Direction  Content
// box       in         box corners and instanced flag
// res       out        cast_shadow keep flag
// cfg       in         write enable, register index, write data
//
// One box is taken per cycle, unless the input is stalled, through 28 register stages.
// The 12-stage divider forms the cone push distance.
// A write of the cone cosine starts a square root that forms the sine; no box is taken while it runs.
// Reset clears the configuration registers and valid bits to zero and sets the sine to one.
// A held result stalls the whole pipeline; nothing moves until it is taken.
`include "light_volume_box_cull_assert.svh"
module light_volume_box_cull import lvbc_pkg::*; (
	input logic clk,
	input logic arst_n,
	lvbc_box_if.sink box,
	lvbc_res_if.source res,
	input logic cfg_we,
	input logic [CFG_IDX_W-1:0] cfg_index,
	input logic [CFG_DATA_W-1:0] cfg_data
);
	logic mode_q;
	logic [2:0][31:0] pos_q;
	logic [RADIUS_W-1:0] radius_q;
	logic [DIR_W-1:0] dir_q;
	logic [27:0] cos_sq_q;
	logic [28:0] sq_n_q;
	logic [28:0] sq_r_q;
	logic [28:0] sq_bit_q;
	logic sqrt_busy;
	logic [14:0] sine;
	logic [13:0] cos_in;
	logic [27:0] cos_sq_c;
	logic cos_wr;
	logic [28:0] sq_t;
	logic en;

	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_s7;
	logic v_s8, v_s9, v_s10, v_s11, v_s12, v_s13, v_s14, v_s15, v_s16;
	logic [DIV_STAGES-1:0] div_v;
	div_t div_s [DIV_STAGES];
	div_t div_in [DIV_STAGES];

	logic [2:0][31:0] mn_c, mx_c;
	logic [2:0][33:0] rel_c;
	logic [2:0][32:0] h2_c;
	logic [2:0][33:0] rel_s1, rel_s2, rel_s3, rel_s4, rel_s5, rel_s6, rel_s7;
	logic [2:0][32:0] h2_s1;
	flags_t fl_s1, fl_s2, fl_s3, fl_s4, fl_s5, fl_s6, fl_s7;
	flags_t fl_s8, fl_s9, fl_s10, fl_s11, fl_s12, fl_s13, fl_s14, fl_s15;
	logic [32:0] hmax_c;
	logic [31:0] m2_s2;
	logic [2:0][32:0] mag_c, mag_s2;
	logic [62:0] d2p_s3;
	logic [2:0][65:0] rsq_s3;
	logic [62:0] d2r_c;
	logic [32:0] d2_s4, d2_s5, d2_s6, d2_s7;
	logic [67:0] sqrel_s4, sqrel_s5, sqrel_s6;
	logic [33:0] r2_s5;
	logic [67:0] r2sq_s6;
	logic [65:0] d2sq_s6;

	logic [2:0][15:0] dir_c;
	logic [K_W-1:0] k_c;
	logic [2:0][56:0] prod_s8;
	logic [2:0][33:0] rel_s8;
	logic [2:0][56:0] w_s9, w_s10;
	logic [2:0][55:0] wmag_c;
	logic [55:0] wor_c;
	logic [5:0] blen_c;
	logic [4:0] sh_s10;
	logic [2:0][30:0] w_s11;
	logic [2:0][46:0] pd_s12;
	logic [2:0][60:0] wsq_s12;
	logic signed [46:0] pd_c [3];
	logic signed [61:0] wsq_c [3];
	logic [48:0] dot_s13;
	logic [61:0] lw_s13;
	logic dpos_s14, dpos_s15;
	logic [45:0] phh_s14;
	logic [46:0] phl_s14;
	logic [47:0] pll_s14;
	logic [58:0] qh_s14, ql_s14;
	logic [95:0] dsq_s15, rhs_s15;
	logic keep_s16;

	function automatic div_t div_step(div_t a, logic [14:0] d);
		div_t r;
		logic [15:0] rem16;
		r = a;
		for (int j = 0; j < DIV_STEP; j++) begin
			rem16 = {r.rem, r.num[DIV_W-1]};
			if (rem16 >= {1'b0, d}) begin
				r.rem = 15'(rem16 - {1'b0, d});
				r.num = {r.num[DIV_W-2:0], 1'b1};
			end else begin
				r.rem = rem16[14:0];
				r.num = {r.num[DIV_W-2:0], 1'b0};
			end
		end
		return r;
	endfunction

	assign sqrt_busy = |sq_bit_q;
	assign sine = sq_r_q[14:0];
	assign cos_in = cfg_data[COS_W-1:0];
	assign cos_sq_c = {14'd0, cos_in} * {14'd0, cos_in};
	assign cos_wr = cfg_we && (cfg_index == CFG_COS_OUTER);
	assign sq_t = sq_r_q + sq_bit_q;
	assign en = !v_s16 || res.ready;
	assign box.ready = en && !sqrt_busy;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= 1'b0;
			pos_q <= '0;
			radius_q <= '0;
			dir_q <= '0;
			cos_sq_q <= '0;
			sq_n_q <= '0;
			sq_r_q <= 29'd16384;
			sq_bit_q <= '0;
		end else begin
			if (sqrt_busy && !cos_wr) begin
				if (sq_n_q >= sq_t) begin
					sq_n_q <= sq_n_q - sq_t;
					sq_r_q <= (sq_r_q >> 1) + sq_bit_q;
				end else begin
					sq_r_q <= sq_r_q >> 1;
				end
				sq_bit_q <= sq_bit_q >> 2;
			end
			if (cfg_we) begin
				unique case (cfg_index)
					CFG_MODE: mode_q <= cfg_data[0];
					CFG_POS_X: pos_q[0] <= cfg_data[31:0];
					CFG_POS_Y: pos_q[1] <= cfg_data[31:0];
					CFG_POS_Z: pos_q[2] <= cfg_data[31:0];
					CFG_RADIUS: radius_q <= cfg_data[RADIUS_W-1:0];
					CFG_CONE_DIR: dir_q <= cfg_data[DIR_W-1:0];
					CFG_COS_OUTER: begin
						cos_sq_q <= cos_sq_c;
						sq_n_q <= 29'h1000_0000 - {1'b0, cos_sq_c};
						sq_r_q <= '0;
						sq_bit_q <= 29'h1000_0000;
					end
					default: ;
				endcase
			end
		end
	end

	always_comb begin
		mn_c[0] = box.box_min_x;
		mn_c[1] = box.box_min_y;
		mn_c[2] = box.box_min_z;
		mx_c[0] = box.box_max_x;
		mx_c[1] = box.box_max_y;
		mx_c[2] = box.box_max_z;
		for (int i = 0; i < 3; i++) begin
			rel_c[i] = {{2{mn_c[i][31]}}, mn_c[i]} + {{2{mx_c[i][31]}}, mx_c[i]}
				- {pos_q[i][31], pos_q[i], 1'b0};
			h2_c[i] = {mx_c[i][31], mx_c[i]} - {mn_c[i][31], mn_c[i]};
			mag_c[i] = rel_s1[i][33] ? 33'(-rel_s1[i]) : rel_s1[i][32:0];
			dir_c[i] = dir_q[16*i +: 16];
		end
		hmax_c = h2_s1[0];
		if ($signed(h2_s1[1]) > $signed(hmax_c)) hmax_c = h2_s1[1];
		if ($signed(h2_s1[2]) > $signed(hmax_c)) hmax_c = h2_s1[2];
		d2r_c = d2p_s3 + 63'(1 << 29);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			{v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_s7} <= '0;
			{v_s8, v_s9, v_s10, v_s11, v_s12, v_s13, v_s14, v_s15, v_s16} <= '0;
			div_v <= '0;
		end else if (en) begin
			v_s1 <= box.valid && !sqrt_busy;
			{v_s7, v_s6, v_s5, v_s4, v_s3, v_s2} <= {v_s6, v_s5, v_s4, v_s3, v_s2, v_s1};
			div_v <= {div_v[DIV_STAGES-2:0], v_s7};
			v_s8 <= div_v[DIV_STAGES-1];
			{v_s16, v_s15, v_s14, v_s13, v_s12, v_s11, v_s10, v_s9} <=
				{v_s15, v_s14, v_s13, v_s12, v_s11, v_s10, v_s9, v_s8};
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rel_s1 <= rel_c;
			h2_s1 <= h2_c;
			fl_s1 <= '{inst: box.instanced, pt: 1'b0, apex: 1'b0};

			m2_s2 <= hmax_c[32] ? '0 : hmax_c[31:0];
			mag_s2 <= mag_c;
			rel_s2 <= rel_s1;
			fl_s2 <= fl_s1;

			d2p_s3 <= m2_s2 * SQRT3_Q30;
			for (int i = 0; i < 3; i++) rsq_s3[i] <= mag_s2[i] * mag_s2[i];
			rel_s3 <= rel_s2;
			fl_s3 <= fl_s2;

			d2_s4 <= d2r_c[62:30];
			sqrel_s4 <= 68'(rsq_s3[0]) + 68'(rsq_s3[1]) + 68'(rsq_s3[2]);
			rel_s4 <= rel_s3;
			fl_s4 <= fl_s3;

			r2_s5 <= 34'(d2_s4) + {2'b0, radius_q, 1'b0};
			d2_s5 <= d2_s4;
			sqrel_s5 <= sqrel_s4;
			rel_s5 <= rel_s4;
			fl_s5 <= fl_s4;

			r2sq_s6 <= r2_s5 * r2_s5;
			d2sq_s6 <= d2_s5 * d2_s5;
			d2_s6 <= d2_s5;
			sqrel_s6 <= sqrel_s5;
			rel_s6 <= rel_s5;
			fl_s6 <= fl_s5;

			d2_s7 <= d2_s6;
			rel_s7 <= rel_s6;
			fl_s7 <= '{inst: fl_s6.inst, pt: sqrel_s6 < r2sq_s6,
				apex: sqrel_s6 < {2'b0, d2sq_s6}};
		end
	end

	assign div_in[0] = '{num: {1'b0, d2_s7, 14'd0}, rem: '0, rel: rel_s7, flags: fl_s7};

	for (genvar g = 0; g < DIV_STAGES; g++) begin : g_div
		if (g > 0) begin : g_link
			assign div_in[g] = div_s[g-1];
		end
		always_ff @(posedge clk) begin
			if (en) begin
				div_s[g] <= div_step(div_in[g], sine);
			end
		end
	end

	assign k_c = div_s[DIV_STAGES-1].num[K_W-1:0];

	always_comb begin
		wor_c = '0;
		for (int i = 0; i < 3; i++) begin
			wmag_c[i] = w_s9[i][56] ? 56'(-w_s9[i]) : w_s9[i][55:0];
			wor_c = wor_c | wmag_c[i];
			pd_c[i] = $signed(w_s11[i]) * $signed(dir_c[i]);
			wsq_c[i] = $signed(w_s11[i]) * $signed(w_s11[i]);
		end
		blen_c = '0;
		for (int b = 0; b < 56; b++) begin
			if (wor_c[b]) blen_c = 6'(b + 1);
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				prod_s8[i] <= $signed(dir_c[i]) * $signed({1'b0, k_c});
				w_s9[i] <= {{9{rel_s8[i][33]}}, rel_s8[i], 14'd0} + prod_s8[i];
				w_s11[i] <= 31'($signed(w_s10[i]) >>> sh_s10);
				pd_s12[i] <= pd_c[i];
				wsq_s12[i] <= wsq_c[i][60:0];
			end
			rel_s8 <= div_s[DIV_STAGES-1].rel;
			fl_s8 <= div_s[DIV_STAGES-1].flags;
			fl_s9 <= fl_s8;

			w_s10 <= w_s9;
			sh_s10 <= (blen_c > 6'd30) ? 5'(blen_c - 6'd30) : 5'd0;
			fl_s10 <= fl_s9;
			fl_s11 <= fl_s10;
			fl_s12 <= fl_s11;

			dot_s13 <= {{2{pd_s12[0][46]}}, pd_s12[0]} + {{2{pd_s12[1][46]}}, pd_s12[1]}
				+ {{2{pd_s12[2][46]}}, pd_s12[2]};
			lw_s13 <= 62'(wsq_s12[0]) + 62'(wsq_s12[1]) + 62'(wsq_s12[2]);
			fl_s13 <= fl_s12;

			dpos_s14 <= !dot_s13[48] && (dot_s13 != '0);
			phh_s14 <= dot_s13[46:24] * dot_s13[46:24];
			phl_s14 <= dot_s13[46:24] * dot_s13[23:0];
			pll_s14 <= dot_s13[23:0] * dot_s13[23:0];
			qh_s14 <= cos_sq_q * lw_s13[61:31];
			ql_s14 <= cos_sq_q * lw_s13[30:0];
			fl_s14 <= fl_s13;

			dsq_s15 <= (96'(phh_s14) << 48) + (96'(phl_s14) << 25) + 96'(pll_s14);
			rhs_s15 <= (96'(qh_s14) << 31) + 96'(ql_s14);
			dpos_s15 <= dpos_s14;
			fl_s15 <= fl_s14;

			keep_s16 <= fl_s15.inst || (mode_q ?
				((dpos_s15 && (rhs_s15 < dsq_s15)) || fl_s15.apex) : fl_s15.pt);
		end
	end

	assign res.valid = v_s16;
	assign res.cast_shadow = keep_s16;

	`LVBC_ASSERT(a_busy_blocks_input, sqrt_busy |-> !box.ready, "box taken during sine update")
	`LVBC_ASSERT_NEXT(a_cos_write_starts, cos_wr, sqrt_busy, "sine update did not start")
	`LVBC_ASSERT(a_sine_range, !sqrt_busy |-> (sine >= 15'd181) && (sq_r_q[28:15] == '0), "sine out of range")
endmodule

>>> test/tb_light_volume_box_cull.sv
// Self-checking testbench of the light volume box cull block with random and directed boxes.
`timescale 1ns / 1ps
module tb_light_volume_box_cull;
	import lvbc_pkg::*;

	typedef struct packed {
		logic [2:0][31:0] lo;
		logic [2:0][31:0] hi;
		logic inst;
	} box_t;

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	lvbc_box_if box ();
	lvbc_res_if res ();

	light_volume_box_cull u_top (
		.clk(clk),
		.arst_n(arst_n),
		.box(box.sink),
		.res(res.source),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	logic mode_r;
	logic [2:0][31:0] pos_r;
	logic [30:0] radius_r;
	logic [47:0] dir_r;
	logic [13:0] cos_r;

	box_t pending_boxes[$];
	bit expected_keep[$];
	bit sent;
	bit quiet;
	int src_idle, snk_idle;
	int errors, n_boxes, n_kept, n_phases;

	function automatic logic [127:0] mag(longint v);
		return v < 0 ? 128'(-v) : 128'(v);
	endfunction

	function automatic logic [127:0] sum_sq(longint a, longint b, longint c);
		return mag(a) * mag(a) + mag(b) * mag(b) + mag(c) * mag(c);
	endfunction

	function automatic longint unsigned int_sqrt(longint unsigned n);
		longint unsigned r, b;
		r = 0;
		b = 64'd1 << 62;
		while (b > n)
			b >>= 2;
		while (b != 0) begin
			if (n >= r + b) begin
				n -= r + b;
				r = (r >> 1) + b;
			end else begin
				r >>= 1;
			end
			b >>= 2;
		end
		return r;
	endfunction

	function automatic bit cull_keep(box_t b);
		longint rel[3], w[3], dir[3], m2, h, dot, lo, hi;
		logic [127:0] d2, r2, rel_sq, sn, k, mx, cc;
		int s;
		bit cone;
		m2 = 0;
		for (int i = 0; i < 3; i++) begin
			lo = longint'($signed(b.lo[i]));
			hi = longint'($signed(b.hi[i]));
			h = hi - lo;
			if (h > m2)
				m2 = h;
			rel[i] = lo + hi - 2 * longint'($signed(pos_r[i]));
		end
		d2 = (128'(m2) * 128'(SQRT3_Q30) + 128'h2000_0000) >> 30;
		rel_sq = sum_sq(rel[0], rel[1], rel[2]);
		if (b.inst)
			return 1'b1;
		if (!mode_r) begin
			r2 = d2 + 2 * 128'(radius_r);
			return rel_sq < r2 * r2;
		end
		cc = 128'(cos_r) * 128'(cos_r);
		sn = 128'(int_sqrt(64'd268435456 - 64'(cc)));
		k = (d2 << 14) / sn;
		mx = 0;
		for (int i = 0; i < 3; i++) begin
			dir[i] = longint'($signed(dir_r[16*i +: 16]));
			w[i] = rel[i] * 16384 + dir[i] * longint'(k);
			if (mag(w[i]) > mx)
				mx = mag(w[i]);
		end
		s = 0;
		while ((mx >> s) >= 128'h4000_0000)
			s++;
		dot = 0;
		for (int i = 0; i < 3; i++) begin
			w[i] = w[i] >>> s;
			dot += w[i] * dir[i];
		end
		cone = dot > 0 && (cc * sum_sq(w[0], w[1], w[2]) < mag(dot) * mag(dot));
		return cone || rel_sq < d2 * d2;
	endfunction

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	initial begin
		#2ms;
		$display("tb_light_volume_box_cull NOT OK");
		$finish;
	end

	always @(posedge clk) begin
		if (arst_n && box.valid && box.ready) begin
			expected_keep.push_back(cull_keep(box_t'({box.box_min_z, box.box_min_y,
				box.box_min_x, box.box_max_z, box.box_max_y, box.box_max_x, box.instanced})));
			n_boxes++;
			sent <= 1'b1;
		end else begin
			sent <= 1'b0;
		end
		if (arst_n && res.valid && res.ready) begin
			if (expected_keep.size() == 0) begin
				$display("%0t: unexpected transfer, expected none, actual cast_shadow %0b",
					$time, res.cast_shadow);
				errors++;
			end else begin
				if (res.cast_shadow !== expected_keep[0]) begin
					$display("%0t: cast_shadow mismatch, expected %0b, actual %0b",
						$time, expected_keep[0], res.cast_shadow);
					errors++;
				end
				n_kept += expected_keep[0];
				void'(expected_keep.pop_front());
			end
		end
	end

	always @(negedge clk) begin
		box_t nb;
		if (arst_n && (!box.valid || sent)) begin
			if (src_idle > 0) begin
				src_idle--;
				box.valid <= 1'b0;
			end else if (!quiet && $urandom_range(0, 15) == 0) begin
				src_idle = $urandom_range(1, 13);
				box.valid <= 1'b0;
			end else if (pending_boxes.size() > 0) begin
				nb = pending_boxes.pop_front();
				{box.box_min_z, box.box_min_y, box.box_min_x} <= nb.lo;
				{box.box_max_z, box.box_max_y, box.box_max_x} <= nb.hi;
				box.instanced <= nb.inst;
				box.valid <= 1'b1;
			end else begin
				box.valid <= 1'b0;
			end
		end
		if (snk_idle > 0) begin
			snk_idle--;
			res.ready <= 1'b0;
		end else if (!quiet && $urandom_range(0, 15) == 0) begin
			snk_idle = $urandom_range(1, 13);
			res.ready <= 1'b0;
		end else begin
			res.ready <= 1'b1;
		end
	end

	task automatic write_reg(cfg_idx_t idx, logic [47:0] val);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		case (idx)
			CFG_MODE: mode_r = val[0];
			CFG_POS_X: pos_r[0] = val[31:0];
			CFG_POS_Y: pos_r[1] = val[31:0];
			CFG_POS_Z: pos_r[2] = val[31:0];
			CFG_RADIUS: radius_r = val[30:0];
			CFG_CONE_DIR: dir_r = val;
			CFG_COS_OUTER: cos_r = val[13:0];
			default: ;
		endcase
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic drain();
		while (pending_boxes.size() > 0 || box.valid || expected_keep.size() > 0)
			@(posedge clk);
		repeat (40) @(posedge clk);
	endtask

	task automatic write_all(logic md, logic [95:0] p, logic [30:0] rd, logic [47:0] d,
		logic [13:0] c);
		write_reg(CFG_MODE, 48'(md));
		write_reg(CFG_POS_X, 48'(p[31:0]));
		write_reg(CFG_POS_Y, 48'(p[63:32]));
		write_reg(CFG_POS_Z, 48'(p[95:64]));
		write_reg(CFG_RADIUS, 48'(rd));
		write_reg(CFG_CONE_DIR, d);
		write_reg(CFG_COS_OUTER, 48'(c));
		n_phases++;
	endtask

	function automatic logic [31:0] rnd_signed(int bits);
		logic [31:0] v;
		v = $urandom();
		if (bits < 32)
			v = v & ((32'd1 << bits) - 1);
		return $urandom_range(0, 1) ? -v : v;
	endfunction

	function automatic box_t rnd_box();
		box_t b;
		logic [31:0] c, h, t;
		int kind, sc, hs;
		kind = $urandom_range(0, 19);
		sc = $urandom_range(8, 32);
		hs = $urandom_range(4, 30);
		for (int i = 0; i < 3; i++) begin
			if (kind == 0) begin
				b.lo[i] = $urandom();
				b.hi[i] = $urandom();
			end else begin
				c = pos_r[i] + rnd_signed(sc);
				h = $urandom() & ((32'd1 << hs) - 1);
				b.lo[i] = c - h;
				b.hi[i] = c + h;
				if (kind == 1) begin
					t = b.lo[i];
					b.lo[i] = b.hi[i];
					b.hi[i] = t;
				end
			end
		end
		b.inst = $urandom_range(0, 7) == 0;
		return b;
	endfunction

	function automatic logic [47:0] rnd_dir();
		logic [47:0] d;
		int ax;
		if ($urandom_range(0, 3) == 0)
			return 48'({$urandom(), $urandom()});
		ax = $urandom_range(0, 2);
		d = '0;
		d[16*ax +: 16] = $urandom_range(0, 1) ? 16'h4000 : 16'hC000;
		d[16*((ax+1)%3) +: 16] = 16'(rnd_signed(10));
		return d;
	endfunction

	initial begin
		box_t b;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		box.valid = 1'b0;
		box.box_min_x = '0;
		box.box_min_y = '0;
		box.box_min_z = '0;
		box.box_max_x = '0;
		box.box_max_y = '0;
		box.box_max_z = '0;
		box.instanced = 1'b0;
		res.ready = 1'b0;
		mode_r = 1'b0;
		pos_r = '0;
		radius_r = '0;
		dir_r = '0;
		cos_r = '0;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		for (int ph = 0; ph < 4; ph++) begin
			case (ph)
				0: write_all(1'b0, {3{32'h8000_0000}}, 31'h7FFF_FFFF, 48'hFFFF_FFFF_FFFF, 14'd0);
				1: write_all(1'b1, {3{32'h7FFF_FFFF}}, 31'd0, 48'h8000_8000_8000, 14'h3FFF);
				2: write_all(1'b1, '0, 31'd0, 48'h0000_0000_4000, 14'd11585);
				default: write_all(1'b0, '0, 31'h0001_0000, 48'h0000_4000_0000, 14'd8192);
			endcase
			b.lo = {3{32'h8000_0000}};
			b.hi = {3{32'h7FFF_FFFF}};
			b.inst = 1'b0;
			pending_boxes.push_back(b);
			b.inst = 1'b1;
			pending_boxes.push_back(b);
			b.lo = {3{32'h7FFF_FFFF}};
			b.hi = {3{32'h8000_0000}};
			b.inst = 1'b0;
			pending_boxes.push_back(b);
			b.lo = pos_r;
			b.hi = pos_r;
			pending_boxes.push_back(b);
			b.lo = {pos_r[2] - 32'h100, pos_r[1] - 32'h100, pos_r[0] + 32'h0004_0000};
			b.hi = {pos_r[2] + 32'h100, pos_r[1] + 32'h100, pos_r[0] + 32'h0006_0000};
			pending_boxes.push_back(b);
			drain();
		end

		for (int ph = 0; ph < 8; ph++) begin
			write_all(1'($urandom_range(0, 1)),
				$urandom_range(0, 2) == 0 ? {$urandom(), $urandom(), $urandom()}
					: {rnd_signed(24), rnd_signed(24), rnd_signed(24)},
				31'($urandom() >> ($urandom_range(1, 24))), rnd_dir(),
				14'($urandom_range(0, 16383)));
			quiet = ph == 7;
			for (int i = 0; i < 190; i++)
				pending_boxes.push_back(rnd_box());
			drain();
		end

		$display("Covered %0d boxes over %0d register settings, %0d kept for the shadow map.",
			n_boxes, n_phases, n_kept);
		if (errors == 0)
			$display("tb_light_volume_box_cull OK");
		else
			$display("tb_light_volume_box_cull NOT OK");
		$finish;
	end
endmodule
